// ===== sv/dtq_pkg.sv =====
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned DELTA_W = 28;
  localparam int unsigned GRID_W  = 16;
  localparam int unsigned GROUP_W = 7;

  localparam logic [GRID_W-1:0]  GRID_RESET = 16'd120;
  localparam logic [6:0]         GROUP_MASK = 7'h7F;
  localparam logic [7:0]         CONT_BIT   = 8'h80;
  localparam logic [7:0]         BYTE_MASK  = 8'hFF;
  localparam logic [DELTA_W-1:0] DELTA_MAX  = 28'hFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // one vlq byte: group idx of the delta, continuation bit unless idx is zero
  function automatic logic [7:0] vlq_byte(input logic [DELTA_W-1:0] delta,
                                          input logic [1:0] idx);
    logic [GROUP_W-1:0] grp;
    logic [7:0] b;
    case (idx)
      2'd3:    grp = delta[27:21] & GROUP_MASK;
      2'd2:    grp = delta[20:14] & GROUP_MASK;
      2'd1:    grp = delta[13:7] & GROUP_MASK;
      default: grp = delta[6:0] & GROUP_MASK;
    endcase
    b = {1'b0, grp};
    if (idx != 2'd0) begin
      b = b | CONT_BIT;
    end
    return b & BYTE_MASK;
  endfunction

  // index of the most significant nonzero group (0 for a delta below 128)
  function automatic logic [1:0] top_group(input logic [DELTA_W-1:0] delta);
    logic [1:0] idx;
    if (delta[27:21] != 7'd0) begin
      idx = 2'd3;
    end else if (delta[20:14] != 7'd0) begin
      idx = 2'd2;
    end else if (delta[13:7] != 7'd0) begin
      idx = 2'd1;
    end else begin
      idx = 2'd0;
    end
    return idx;
  endfunction

endpackage

// ===== sv/delta_time_quantizer_vlq_top.sv =====
`timescale 1ns / 1ps
// sequence: accept, 32 steps of one-bit restoring remainder, one rounding step, then
//   the first byte is on the output
// a new event is taken only once the last byte of the previous one is out; the
//   32-step remainder loop runs through one 17-bit subtractor
// reset (synchronous, rst_n low): positions cleared, grid base back to 120, idle
module delta_time_quantizer_vlq_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtq_pkg::GRID_W-1:0]    cfg_grid_base,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dtq_pkg::DELTA_W-1:0]   in_raw_delta,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_vlq_byte,
  output logic                          out_is_last,
  output logic [dtq_pkg::DELTA_W-1:0]   out_quantized_delta
);

  dtq_pkg::state_t state_r, state_nxt;

  logic [dtq_pkg::GRID_W-1:0]  grid_base_r;
  logic [dtq_pkg::POS_W-1:0]   raw_pos_r, raw_pos_nxt;
  logic [dtq_pkg::POS_W-1:0]   q_pos_r, q_pos_nxt;
  logic [dtq_pkg::POS_W-1:0]   div_sh_r, div_sh_nxt;     // dividend bits still to shift in
  logic [dtq_pkg::GRID_W-1:0]  rem_r, rem_nxt;
  logic [4:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [dtq_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic [1:0]                  grp_idx_r, grp_idx_nxt;   // group now on the output
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;

  // shared datapath signals
  logic [dtq_pkg::GRID_W-1:0]  base_eff;
  logic [dtq_pkg::GRID_W:0]    rem_shift;
  logic                        rem_ge;
  logic                        round_up;
  logic [dtq_pkg::POS_W-1:0]   q_new;
  logic [dtq_pkg::POS_W-1:0]   delta_full;
  logic [dtq_pkg::DELTA_W-1:0] delta_sat;
  logic                        in_xfer;
  logic                        out_xfer;

  // a zero grid behaves as a grid of one tick
  assign base_eff = (grid_base_r == '0) ? dtq_pkg::GRID_W'(1) : grid_base_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // remainder step: shift in the next dividend bit, subtract the grid if it fits
  assign rem_shift = {rem_r, div_sh_r[dtq_pkg::POS_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, base_eff};

  // nearest grid point, ties up; raw - rem is the grid point below, no multiply needed
  assign round_up   = {rem_r, 1'b0} >= {1'b0, base_eff};
  assign q_new      = raw_pos_r - dtq_pkg::POS_W'(rem_r)
                      + (round_up ? dtq_pkg::POS_W'(base_eff) : '0);
  assign delta_full = q_new - q_pos_r;
  assign delta_sat  = (delta_full[dtq_pkg::POS_W-1:dtq_pkg::DELTA_W] != '0) ?
                      dtq_pkg::DELTA_MAX : delta_full[dtq_pkg::DELTA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtq_pkg::ST_IDLE;
      grid_base_r <= dtq_pkg::GRID_RESET;
      raw_pos_r   <= '0;
      q_pos_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      raw_pos_r   <= raw_pos_nxt;
      q_pos_r     <= q_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        grid_base_r <= cfg_grid_base;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    div_sh_r   <= div_sh_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    delta_r    <= delta_nxt;
    grp_idx_r  <= grp_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    raw_pos_nxt   = raw_pos_r;
    q_pos_nxt     = q_pos_r;
    div_sh_nxt    = div_sh_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    delta_nxt     = delta_r;
    grp_idx_nxt   = grp_idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      dtq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          // running position wraps mod 2^32
          raw_pos_nxt = raw_pos_r + dtq_pkg::POS_W'(in_raw_delta);
          div_sh_nxt  = raw_pos_r + dtq_pkg::POS_W'(in_raw_delta);
          rem_nxt     = '0;
          bit_cnt_nxt = '1;
          state_nxt   = dtq_pkg::ST_DIV;
        end
      end
      dtq_pkg::ST_DIV: begin
        rem_nxt    = rem_ge ? dtq_pkg::GRID_W'(rem_shift - {1'b0, base_eff})
                            : rem_shift[dtq_pkg::GRID_W-1:0];
        div_sh_nxt = {div_sh_r[dtq_pkg::POS_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 5'd1;
        if (bit_cnt_r == '0) begin
          state_nxt = dtq_pkg::ST_ROUND;
        end
      end
      dtq_pkg::ST_ROUND: begin
        // quantized position keeps the unsaturated value
        q_pos_nxt     = q_new;
        delta_nxt     = delta_sat;
        grp_idx_nxt   = dtq_pkg::top_group(delta_sat);
        out_byte_nxt  = dtq_pkg::vlq_byte(delta_sat, dtq_pkg::top_group(delta_sat));
        out_last_nxt  = dtq_pkg::top_group(delta_sat) == 2'd0;
        out_valid_nxt = 1'b1;
        state_nxt     = dtq_pkg::ST_EMIT;
      end
      dtq_pkg::ST_EMIT: begin
        if (out_xfer) begin
          if (out_last_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = dtq_pkg::ST_IDLE;
          end else begin
            // next lower group
            grp_idx_nxt  = grp_idx_r - 2'd1;
            out_byte_nxt = dtq_pkg::vlq_byte(delta_r, grp_idx_r - 2'd1);
            out_last_nxt = (grp_idx_r - 2'd1) == 2'd0;
          end
        end
      end
      default: begin
        state_nxt = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  assign cfg_ready           = 1'b1;
  assign in_stall            = state_r != dtq_pkg::ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_vlq_byte        = out_byte_r;
  assign out_is_last         = out_last_r;
  assign out_quantized_delta = delta_r;

  // no input transfer while a byte is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // continuation bit agrees with the last flag
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vlq_byte[7] == !out_is_last))
    else $error("continuation bit does not match last flag");

  // after the last byte the block is idle again
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_is_last) |=> (!out_valid && !in_stall))
    else $error("event did not finish after its last byte");

  // a non-final byte is followed by another byte of the same event
  a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_is_last) |=>
      (out_valid && $stable(out_quantized_delta)))
    else $error("event ended before its last byte");

endmodule

// ===== bench/tb_delta_time_quantizer_vlq_top.sv =====
`timescale 1ns / 1ps

module tb_delta_time_quantizer_vlq_top;

  localparam int unsigned DELTA_W = dtq_pkg::DELTA_W;
  localparam int unsigned GRID_W  = dtq_pkg::GRID_W;

  // run control
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;    // a bit more than accept-to-first-byte
  localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off, far beyond one event
  localparam int unsigned MAX_REPORTS  = 10;

  // 28-bit saturation ceiling of the quantized delta
  localparam logic [31:0] DELTA_CEIL = 32'h0FFF_FFFF;
  localparam logic [7:0]  CONT_FLAG  = 8'h80;
  localparam logic [6:0]  GROUP_BITS = 7'h7F;

  typedef struct packed {
    logic [7:0]         vlq_byte;
    logic               is_last;
    logic [DELTA_W-1:0] quantized_delta;
  } vlq_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [GRID_W-1:0]  cfg_grid_base;
  logic               in_valid;
  logic               in_stall;
  logic [DELTA_W-1:0] in_raw_delta;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_vlq_byte;
  logic               out_is_last;
  logic [DELTA_W-1:0] out_quantized_delta;

  // shadow of the block: grid register and both running positions
  logic [GRID_W-1:0]  grid_shadow;
  logic [31:0]        raw_pos;
  logic [31:0]        quant_pos;

  // bytes still owed by the block, oldest first
  vlq_result_t        vlq_expected[$];

  int unsigned        fail_count    = 0;
  int unsigned        cycle_count   = 0;
  int unsigned        hold_requests = 0;
  int unsigned        holds_done    = 0;
  bit                 idle_on       = 1'b1;

  delta_time_quantizer_vlq_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_grid_base       (cfg_grid_base),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_raw_delta        (in_raw_delta),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_vlq_byte        (out_vlq_byte),
    .out_is_last         (out_is_last),
    .out_quantized_delta (out_quantized_delta)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung block ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
  endfunction

  // advance the shadow by one delta and queue the vlq bytes it produces
  function automatic void predict_vlq(input logic [DELTA_W-1:0] delta_in);
    logic [31:0] base;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [31:0] q;
    logic [31:0] delta;
    logic [6:0]  grp;
    vlq_result_t res;
    int          n;
    int          k;
    // a zero grid behaves as a grid of one tick
    base = (grid_shadow == '0) ? 32'd1 : {16'd0, grid_shadow};
    raw_pos = raw_pos + {4'd0, delta_in};
    quot = raw_pos / base;
    rem  = raw_pos - quot * base;
    // nearest multiple, an exact half step goes up; wraps mod 2^32
    if (rem < base - rem) begin
      q = quot * base;
    end else begin
      q = quot * base + base;
    end
    delta = q - quant_pos;
    quant_pos = q;
    if (delta > DELTA_CEIL) begin
      delta = DELTA_CEIL;
    end
    // number of 7-bit groups, at least one so a zero delta is a single 0x00
    n = 1;
    while (n < 4 && (delta >> (7 * n)) != 0) begin
      n++;
    end
    // most significant group first, continuation flag on all but the last
    for (k = 0; k < n; k++) begin
      grp = 7'(delta >> (7 * (n - 1 - k))) & GROUP_BITS;
      res.is_last         = (k == n - 1);
      res.vlq_byte        = res.is_last ? {1'b0, grp} : ({1'b0, grp} | CONT_FLAG);
      res.quantized_delta = delta[DELTA_W-1:0];
      vlq_expected.push_back(res);
    end
  endfunction

  // random delta drawn from several shapes, including exact ties on the grid
  function automatic logic [DELTA_W-1:0] rand_delta();
    logic [31:0] base;
    logic [31:0] rem;
    logic [31:0] add;
    case ($urandom_range(0, 5))
      0: rand_delta = DELTA_W'($urandom_range(0, 127));
      1: rand_delta = DELTA_W'($urandom_range(128, 16383));
      2: rand_delta = DELTA_W'($urandom_range(16384, 2097151));
      3: rand_delta = DELTA_W'($urandom & DELTA_CEIL);
      4: begin
        // land on half a step, or one tick either side of it
        base = (grid_shadow == '0) ? 32'd1 : {16'd0, grid_shadow};
        rem  = raw_pos % base;
        add  = ((base - rem) % base) + base / 2 + $urandom_range(0, 2);
        add  = (add == 0) ? 32'd0 : add - 1;
        rand_delta = add[DELTA_W-1:0];
      end
      default: rand_delta = '0;
    endcase
  endfunction

  // one input transfer; optional idle gap first, prediction at acceptance
  task automatic send_delta(input logic [DELTA_W-1:0] value);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_delta <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vlq(value);
  endtask

  // lower valid in the step of the last transfer so nothing more is taken
  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  // wait for every owed byte, then let the pipeline settle
  task automatic wait_drained();
    while (vlq_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // grid write, only with the block idle
  task automatic write_grid(input logic [GRID_W-1:0] value);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_grid_base <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    grid_shadow  = value;
  endtask

  // reset grid of 120: zero delta, round down, exact tie rounding up, widest input
  task automatic test_default_grid();
    send_delta(28'd0);
    send_delta(28'd59);
    send_delta(28'd1);
    send_delta(28'd179);
    send_delta(28'hFFF_FFFF);
    stop_input();
  endtask

  // zero grid acts as one tick: deltas pass through, walk every vlq length boundary
  task automatic test_unit_grid();
    write_grid('0);
    send_delta(28'd127);
    send_delta(28'd128);
    send_delta(28'd16383);
    send_delta(28'd16384);
    send_delta(28'd2097151);
    send_delta(28'd2097152);
    stop_input();
  endtask

  // widest grid: deltas around half of 65535 and rounding past the 28-bit ceiling
  task automatic test_widest_grid();
    write_grid(16'hFFFF);
    send_delta(28'd32767);
    send_delta(28'd1);
    send_delta(28'hFFF_FFFF);
    stop_input();
  endtask

  // push the raw position across 2^32, then shrink the grid so the delta goes negative
  task automatic test_position_wrap();
    write_grid(16'd1000);
    repeat (17) send_delta(28'hFFF_FFFF);
    stop_input();
    write_grid(16'd7);
    send_delta(28'd0);
    stop_input();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // then the sender waits until every byte is out
  task automatic test_output_hold();
    write_grid(16'd96);
    hold_requests++;
    repeat (10) send_delta(rand_delta());
    stop_input();
    wait_drained();
    repeat (4) send_delta(rand_delta());
    stop_input();
  endtask

  // random phases over a spread of grids, idling switched off for the last one
  task automatic test_random_grids();
    logic [GRID_W-1:0] grid;
    int                phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       grid = 16'd1;
        1:       grid = 16'hFFFF;
        2:       grid = GRID_W'($urandom_range(2, 300));
        3:       grid = GRID_W'($urandom);
        4:       grid = GRID_W'($urandom_range(1000, 65535));
        default: grid = GRID_W'($urandom_range(1, 65535));
      endcase
      if (phase == 5) begin
        idle_on = 1'b0;
      end
      write_grid(grid);
      repeat ((phase == 5) ? 14 : 20) send_delta(rand_delta());
      stop_input();
    end
  endtask

  // receiver side: random stall bursts, long hold-offs on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        for (int i = 0; i < LONG_HOLD; i++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // result checker: each output transfer against the oldest owed byte
  always @(posedge clk) begin
    vlq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (vlq_expected.size() == 0) begin
        note_failure($sformatf("unexpected byte %h last %b delta %h",
                               out_vlq_byte, out_is_last, out_quantized_delta));
      end else begin
        want = vlq_expected.pop_front();
        if (out_vlq_byte !== want.vlq_byte || out_is_last !== want.is_last ||
            out_quantized_delta !== want.quantized_delta) begin
          note_failure($sformatf("expected byte %h last %b delta %h, got %h %b %h",
                                 want.vlq_byte, want.is_last, want.quantized_delta,
                                 out_vlq_byte, out_is_last, out_quantized_delta));
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_grid_base = '0;
    in_valid      = 1'b0;
    in_raw_delta  = '0;
    grid_shadow   = dtq_pkg::GRID_RESET;
    raw_pos       = '0;
    quant_pos     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_default_grid();
    test_unit_grid();
    test_widest_grid();
    test_position_wrap();
    test_output_hold();
    test_random_grids();

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
